### rtl/bsrch_pkg.sv
// shared types and constants for the sorted table binary search
`default_nettype none

package bsrch_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned IDX_W  = 4;
   localparam int unsigned POS_W  = 4;
   localparam int unsigned LEN_W  = 5;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_SEARCH = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type                opcode;
      logic [IDX_W-1:0]          entry_index;
      logic signed [WORD_W-1:0]  entry_value;
      logic signed [WORD_W-1:0]  search_key;
   } item_type;

   typedef struct packed {
      logic             hit;
      logic [POS_W-1:0] pos;
   } result_type;

endpackage

`default_nettype wire

### rtl/sorted_table_binary_search.sv
// top level of the sorted table binary search pipeline
//
// req_ channel: one beat per item. opcode OP_LOAD writes entry_value at
// entry_index (ignored beyond the table depth), OP_SEARCH looks up
// search_key among the first table_length entries.
// rsp_ channel: one beat per search, found and position (0 when not found).
// csr_ port: csr_write_enable writes table_length, saturated to the depth.
// A search runs through clog2(TABLE_DEPTH+1) probe stages, one probe each,
// every stage holding its own copy of the table; loads update each copy as
// they pass, so items are served strictly in order.
// Each item is registered in every probe stage, then in the response
// register. Throughput: one item per cycle while rsp_stall is low.
// Reset empties the pipeline and clears table_length; table contents stay
// undefined until loaded.
// While rsp_stall is high the response register holds and bubbles in the
// pipeline close up; req_stall rises only once every stage is full.
`default_nettype none

module sorted_table_binary_search #(
   parameter int unsigned TABLE_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic [bsrch_pkg::IDX_W-1:0]       req_entry_index,
   input  logic signed [bsrch_pkg::WORD_W-1:0] req_entry_value,
   input  logic signed [bsrch_pkg::WORD_W-1:0] req_search_key,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_found,
   output logic [bsrch_pkg::POS_W-1:0]       rsp_position,
   input  logic                              csr_write_enable,
   input  logic [bsrch_pkg::LEN_W-1:0]       csr_write_data
);
   import bsrch_pkg::*;

   localparam int unsigned ADDR_W  = $clog2(TABLE_DEPTH);
   localparam int unsigned BOUND_W = ADDR_W + 2;
   localparam int unsigned PROBES  = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned LEN_X   = ((ADDR_W + 1) > LEN_W) ? (ADDR_W + 1) : LEN_W;

   logic [LEN_W-1:0]          table_length_ff;
   logic [LEN_X-1:0]          len_x;
   logic [LEN_X-1:0]          len_sat;
   logic signed [BOUND_W-1:0] hi0;

   logic                      s_valid [PROBES+1];
   logic                      s_ready [PROBES+1];
   item_type                  s_item  [PROBES+1];
   result_type                s_res   [PROBES+1];
   logic signed [BOUND_W-1:0] s_lo    [PROBES];
   logic signed [BOUND_W-1:0] s_hi    [PROBES];
   logic                      s_done  [PROBES];

   logic                      out_ready;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic                      found_ff;
   logic [POS_W-1:0]          position_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff <= '0;
      end else if (csr_write_enable) begin
         table_length_ff <= csr_write_data;
      end
   end

   assign len_x   = LEN_X'(table_length_ff);
   assign len_sat = (len_x > LEN_X'(TABLE_DEPTH)) ? LEN_X'(TABLE_DEPTH) : len_x;
   assign hi0     = signed'(BOUND_W'(len_sat) - BOUND_W'(1));

   assign s_valid[0]            = req_valid;
   assign req_stall             = !s_ready[0];
   assign s_item[0].opcode      = opcode_type'(req_opcode);
   assign s_item[0].entry_index = req_entry_index;
   assign s_item[0].entry_value = req_entry_value;
   assign s_item[0].search_key  = req_search_key;
   assign s_res[0]              = '0;
   assign s_lo[0]               = '0;
   assign s_hi[0]               = hi0;
   assign s_done[0]             = 1'b0;

   for (genvar g = 0; g < PROBES; g++) begin : g_probe
      if (g < PROBES - 1) begin : g_mid
         bsrch_probe #(.TABLE_DEPTH(TABLE_DEPTH)) u_probe (
            .clock    (clock),
            .reset    (reset),
            .up_valid (s_valid[g]),
            .up_ready (s_ready[g]),
            .up_item  (s_item[g]),
            .up_lo    (s_lo[g]),
            .up_hi    (s_hi[g]),
            .up_done  (s_done[g]),
            .up_res   (s_res[g]),
            .dn_valid (s_valid[g+1]),
            .dn_ready (s_ready[g+1]),
            .dn_item  (s_item[g+1]),
            .dn_lo    (s_lo[g+1]),
            .dn_hi    (s_hi[g+1]),
            .dn_done  (s_done[g+1]),
            .dn_res   (s_res[g+1])
         );
      end else begin : g_last
         bsrch_probe #(.TABLE_DEPTH(TABLE_DEPTH)) u_probe (
            .clock    (clock),
            .reset    (reset),
            .up_valid (s_valid[g]),
            .up_ready (s_ready[g]),
            .up_item  (s_item[g]),
            .up_lo    (s_lo[g]),
            .up_hi    (s_hi[g]),
            .up_done  (s_done[g]),
            .up_res   (s_res[g]),
            .dn_valid (s_valid[g+1]),
            .dn_ready (s_ready[g+1]),
            .dn_item  (s_item[g+1]),
            .dn_lo    (),
            .dn_hi    (),
            .dn_done  (),
            .dn_res   (s_res[g+1])
         );
      end
   end

   // loads leave the pipeline here without a response beat
   assign out_ready       = !rsp_valid_ff || !rsp_stall;
   assign s_ready[PROBES] = out_ready;
   assign rsp_valid_in    = s_valid[PROBES] && (s_item[PROBES].opcode == OP_SEARCH);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         found_ff    <= s_res[PROBES].hit;
         position_ff <= s_res[PROBES].hit ? s_res[PROBES].pos : '0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = found_ff;
   assign rsp_position = position_ff;

endmodule

`default_nettype wire

### rtl/bsrch_probe.sv
// one probe stage of the search pipeline with its own copy of the table
`default_nettype none

module bsrch_probe #(
   parameter int unsigned TABLE_DEPTH = 16,
   localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH),
   localparam int unsigned BOUND_W = ADDR_W + 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       up_valid,
   output logic                       up_ready,
   input  bsrch_pkg::item_type        up_item,
   input  logic signed [BOUND_W-1:0]  up_lo,
   input  logic signed [BOUND_W-1:0]  up_hi,
   input  logic                       up_done,
   input  bsrch_pkg::result_type      up_res,
   output logic                       dn_valid,
   input  logic                       dn_ready,
   output bsrch_pkg::item_type        dn_item,
   output logic signed [BOUND_W-1:0]  dn_lo,
   output logic signed [BOUND_W-1:0]  dn_hi,
   output logic                       dn_done,
   output bsrch_pkg::result_type      dn_res
);
   import bsrch_pkg::*;

   localparam int unsigned XW = ((ADDR_W + 1) > IDX_W) ? (ADDR_W + 1) : IDX_W;

   logic signed [WORD_W-1:0]  mem [TABLE_DEPTH];
   logic                      valid_ff;
   item_type                  item_ff;
   logic signed [BOUND_W-1:0] lo_ff;
   logic signed [BOUND_W-1:0] hi_ff;
   result_type                res_ff;
   logic                      active_ff;
   logic [ADDR_W-1:0]         mid_ff;
   logic signed [WORD_W-1:0]  rdata_ff;

   logic                      take;
   logic signed [BOUND_W-1:0] sum_in;
   logic [ADDR_W-1:0]         mid_in;
   logic                      active_in;
   logic [XW-1:0]             load_idx;
   logic                      load_ok;
   logic signed [BOUND_W-1:0] mid_s;
   logic                      eq;
   logic                      lt;

   assign up_ready  = !valid_ff || dn_ready;
   assign take      = up_valid && up_ready;
   assign sum_in    = up_lo + up_hi;
   assign mid_in    = sum_in[ADDR_W:1];
   assign active_in = !up_done && (up_lo <= up_hi) && (up_item.opcode == OP_SEARCH);
   assign load_idx  = XW'(up_item.entry_index);
   assign load_ok   = (up_item.opcode == OP_LOAD) && (load_idx < XW'(TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff   <= up_item;
         lo_ff     <= up_lo;
         hi_ff     <= up_hi;
         res_ff    <= up_res;
         active_ff <= active_in;
         mid_ff    <= mid_in;
      end
   end

   // loads write this copy as they pass, so a search sees exactly the loads ahead of it
   always_ff @(posedge clock) begin
      if (take) begin
         if (load_ok) begin
            mem[load_idx[ADDR_W-1:0]] <= up_item.entry_value;
         end
         rdata_ff <= mem[mid_in];
      end
   end

   assign mid_s = signed'(BOUND_W'(mid_ff));
   assign eq    = active_ff && (rdata_ff == item_ff.search_key);
   assign lt    = active_ff && (item_ff.search_key < rdata_ff);

   assign dn_valid   = valid_ff;
   assign dn_item    = item_ff;
   assign dn_lo      = (active_ff && !eq && !lt) ? (mid_s + BOUND_W'(1)) : lo_ff;
   assign dn_hi      = lt ? (mid_s - BOUND_W'(1)) : hi_ff;
   assign dn_done    = !active_ff || eq;
   assign dn_res.hit = res_ff.hit || eq;
   assign dn_res.pos = eq ? POS_W'(XW'(mid_ff)) : res_ff.pos;

endmodule

`default_nettype wire

### rtl/bsrch_checker.sv
// port-level assertions for the binary search block, bound to the top level
`default_nettype none

module bsrch_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_found,
   input logic [bsrch_pkg::POS_W-1:0] rsp_position
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found) && $stable(rsp_position))
      else $error("stalled response beat changed");

   // a miss reports position zero
   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_position == '0)
      else $error("miss with non-zero position");

   // reset empties the response register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response beat after reset");

   // with the response side free the pipeline always takes a beat
   a_flow: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("request stalled while response side free");

endmodule

bind sorted_table_binary_search bsrch_checker u_bsrch_checker (.*);

`default_nettype wire
